### src/sorted_value_list_assert.svh
// ----------------------------------------------------------------------------
// sorted_value_list_assert.svh
// Assertion macros used by the sorted value list datapath.
// ----------------------------------------------------------------------------
`ifndef SORTED_VALUE_LIST_ASSERT_SVH
`define SORTED_VALUE_LIST_ASSERT_SVH

// Condition must never hold outside reset.
`define SVL_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("sorted_value_list: forbidden condition seen");

// Antecedent in one cycle implies consequent in the next.
`define SVL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted_value_list: next-cycle check failed");

`endif

### src/svl_pkg.sv
// ----------------------------------------------------------------------------
// svl_pkg
// Types and constants shared by the sorted value list modules.
// ----------------------------------------------------------------------------
package svl_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int VALUE_W    = 32;
	localparam int COUNT_W    = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_DELETED   = 3'd4,
		ST_DEL_MISS  = 3'd5,
		ST_CLEARED   = 3'd6
	} status_t;

	typedef struct packed {
		op_t                        operation;
		logic signed [VALUE_W-1:0]  value;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [COUNT_W-1:0]   entry_count;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_COMPARE,
		S_COMMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic compare;
		logic commit;
	} cmd_t;

endpackage

### src/svl_ctrl.sv
// ----------------------------------------------------------------------------
// svl_ctrl
// Sequencer: accept one item, compare, commit, and track the result slot.
// ----------------------------------------------------------------------------
module svl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output svl_pkg::cmd_t cmd
);
	import svl_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   slot_free;

	assign slot_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_COMPARE;
				end
			end
			S_COMPARE: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall   = (state_q != S_IDLE);
		cmd.capture = (state_q == S_IDLE) && req_valid;
		cmd.compare = (state_q == S_COMPARE);
		cmd.commit  = (state_q == S_COMMIT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

### src/svl_datapath.sv
// ----------------------------------------------------------------------------
// svl_datapath
// Row of compare-and-shift cells, entry count and result register.
// ----------------------------------------------------------------------------
`include "sorted_value_list_assert.svh"

module svl_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  svl_pkg::cmd_t cmd,
	input  svl_pkg::req_t req,
	output svl_pkg::rsp_t rsp
);
	import svl_pkg::*;

	logic signed [VALUE_W-1:0] entries_q [LIST_DEPTH];
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_d;
	op_t                       op_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [LIST_DEPTH-1:0]     lt_q;
	logic [LIST_DEPTH-1:0]     eq_q;
	rsp_t                      rsp_q;

	logic    found;
	logic    full;
	logic    do_insert;
	logic    do_delete;
	status_t status_d;

	// Hold the request for the compare and commit cycles.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= req.operation;
			value_q <= req.value;
		end
	end

	assign found     = |eq_q;
	assign full      = (count_q == CNT_W'(LIST_DEPTH));
	assign do_insert = cmd.commit && (op_q == OP_INSERT) && !full;
	assign do_delete = cmd.commit && (op_q == OP_DELETE) && found;

	// Each cell compares its own entry; cells past the count stay quiet.
	// Since the list is sorted, lt_q is a run of ones from cell zero.
	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		logic occupied;
		assign occupied = (count_q > CNT_W'(i));

		always_ff @(posedge clk) begin
			if (cmd.compare) begin
				lt_q[i] <= occupied && (entries_q[i] < value_q);
				eq_q[i] <= occupied && (entries_q[i] == value_q);
			end
		end

		// Insert: take the value at the first cell not smaller, shift the rest up.
		// Delete: every cell at or past the first match pulls from above.
		always_ff @(posedge clk) begin
			if (do_insert && !lt_q[i]) begin
				if (i == 0) begin
					entries_q[i] <= value_q;
				end else if (lt_q[(i == 0) ? 0 : i-1]) begin
					entries_q[i] <= value_q;
				end else begin
					entries_q[i] <= entries_q[(i == 0) ? 0 : i-1];
				end
			end else if (do_delete && !lt_q[i]) begin
				entries_q[i] <= entries_q[(i == LIST_DEPTH-1) ? i : i+1];
			end
		end
	end

	always_comb begin
		count_d  = count_q;
		status_d = ST_CLEARED;
		unique case (op_q)
			OP_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_INSERTED;
					count_d  = count_q + CNT_W'(1);
				end
			end
			OP_SEARCH: begin
				status_d = found ? ST_FOUND : ST_NOT_FOUND;
			end
			OP_DELETE: begin
				if (found) begin
					status_d = ST_DELETED;
					count_d  = count_q - CNT_W'(1);
				end else begin
					status_d = ST_DEL_MISS;
				end
			end
			OP_CLEAR: begin
				status_d = ST_CLEARED;
				count_d  = '0;
			end
			default: begin
				status_d = ST_CLEARED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.status      <= status_d;
			rsp_q.entry_count <= COUNT_W'(count_d);
		end
	end

	assign rsp = rsp_q;

	`SVL_ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(LIST_DEPTH))
	`SVL_ASSERT_NEXT(a_sorted_prefix, clk, arst_n, cmd.compare, (lt_q & (lt_q + LIST_DEPTH'(1))) == '0)
	`SVL_ASSERT_NEXT(a_insert_grows, clk, arst_n, do_insert, count_q == $past(count_q) + CNT_W'(1))
	`SVL_ASSERT_NEXT(a_clear_empties, clk, arst_n, cmd.commit && (op_q == OP_CLEAR), count_q == '0)

endmodule

### src/sorted_value_list.sv
// A result is registered on commit, after compare; commit waits while the previous
//   result is stalled. Items go one at a time through the controller's three
//   steps (accept, compare, commit) over the single row of compare-and-shift cells.
// A result left waiting in the output register does not block the next accept.
// Reset (arst_n low, asynchronous) empties the list and drops any pending result;
//   stored values need no clearing pass since cells past the count are never read.
// ----------------------------------------------------------------------------
// sorted_value_list
// Bounded multiset of signed 32-bit values kept in ascending order, with
// insert, search, delete-first-match and clear requests.
// ----------------------------------------------------------------------------
module sorted_value_list (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  svl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output svl_pkg::rsp_t rsp
);
	import svl_pkg::*;

	// Commands from the sequencer into the cell row.
	cmd_t cmd;

	// Sequencer: takes an item only when idle, then steps it through the
	// compare and commit cycles; commit waits while the result slot is full.
	svl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// Cell row: each cell compares its entry with the operand, then on commit
	// either holds, takes the operand, or shifts from a neighbor. The count
	// and the registered result live here as well.
	svl_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
